// ===== design/lhbp_pkg.sv =====
package lhbp_pkg;

	// request codes on req_type
	typedef enum logic {
		REQ_LOOKUP = 1'b0,
		REQ_UPDATE = 1'b1
	} lhbp_req_t;

	localparam int unsigned ADDR_W = 64;
	localparam int unsigned SHIFT_W = 2;
	localparam logic [SHIFT_W-1:0] INST_SHIFT_RST = 2'd2;

	// request queue between front and back
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned QPTR_W = 1;
	localparam int unsigned QCNT_W = 2;

	// classified request, as it waits in the queue
	typedef struct packed {
		logic is_update;
		logic taken;
	} lhbp_op_t;

	// queue head as the back end sees it
	typedef struct packed {
		logic     valid;
		lhbp_op_t op;
	} lhbp_head_t;

	// back end status toward the front end
	typedef struct packed {
		logic pop;
		logic init_done;
	} lhbp_stat_t;

endpackage

// ===== design/lhbp_ram.sv =====
module lhbp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/lhbp_front.sv =====
module lhbp_front #(
	parameter int unsigned LOCAL_ENTRIES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [lhbp_pkg::ADDR_W-1:0]         pc,
	input  logic                                taken,
	input  logic [lhbp_pkg::SHIFT_W-1:0]        inst_shift,
	input  lhbp_pkg::lhbp_stat_t                stat,
	output lhbp_pkg::lhbp_head_t                head,
	output logic [$clog2(LOCAL_ENTRIES)-1:0]    head_slot
);

	import lhbp_pkg::*;

	localparam int unsigned SLOT_W = $clog2(LOCAL_ENTRIES);
	localparam logic [SLOT_W-1:0] SLOT_MASK = SLOT_W'(LOCAL_ENTRIES - 1);

	logic [ADDR_W-1:0] shifted;
	logic [SLOT_W-1:0] slot;
	lhbp_op_t          op;
	logic              push;

	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	lhbp_op_t          op_q   [Q_DEPTH];
	logic [SLOT_W-1:0] slot_q [Q_DEPTH];

	// history table slot and classified request
	always_comb begin
		shifted = pc >> inst_shift;
		slot = shifted[SLOT_W-1:0] & SLOT_MASK;
		op.is_update = (req_type == REQ_UPDATE);
		op.taken = taken;
	end

	assign in_ready = stat.init_done && (count_q != QCNT_W'(Q_DEPTH));
	assign push = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (stat.pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !stat.pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && stat.pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q] <= op;
			slot_q[wr_ptr_q] <= slot;
		end
	end

	always_comb begin
		head.valid = (count_q != '0);
		head.op = op_q[rd_ptr_q];
		head_slot = slot_q[rd_ptr_q];
	end

endmodule

// ===== design/lhbp_back.sv =====
module lhbp_back #(
	parameter int unsigned LOCAL_ENTRIES = 1024,
	parameter int unsigned HIST_BITS     = 10,
	parameter int unsigned CTR_BITS      = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lhbp_pkg::lhbp_head_t             head,
	input  logic [$clog2(LOCAL_ENTRIES)-1:0] head_slot,
	output lhbp_pkg::lhbp_stat_t             stat,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             predict_taken
);

	import lhbp_pkg::*;

	localparam int unsigned SLOT_W = $clog2(LOCAL_ENTRIES);
	localparam int unsigned PAT_N  = 2 ** HIST_BITS;
	localparam int unsigned CLR_N  = (LOCAL_ENTRIES > PAT_N) ? LOCAL_ENTRIES : PAT_N;
	localparam int unsigned CLR_W  = $clog2(CLR_N);
	localparam logic [CTR_BITS-1:0] CTR_MAX = {CTR_BITS{1'b1}};

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CTR,
		ST_EXEC
	} state_t;

	state_t              state_q;
	logic [CLR_W-1:0]    clr_q;
	logic                out_valid_q;
	logic                pred_q;
	logic [SLOT_W-1:0]   slot_q;
	lhbp_op_t            op_q;
	logic [HIST_BITS-1:0] hist_q;

	logic                 clearing;
	logic                 do_upd;
	logic                 clr_hist;
	logic                 clr_ctr;
	logic                 out_ok;
	logic [CTR_BITS-1:0]  ctr_next;

	logic                 hist_we;
	logic [SLOT_W-1:0]    hist_waddr;
	logic [HIST_BITS-1:0] hist_wdata;
	logic [SLOT_W-1:0]    hist_raddr;
	logic [HIST_BITS-1:0] hist_rdata;

	logic                 ctr_we;
	logic [HIST_BITS-1:0] ctr_waddr;
	logic [CTR_BITS-1:0]  ctr_wdata;
	logic [HIST_BITS-1:0] ctr_raddr;
	logic [CTR_BITS-1:0]  ctr_rdata;

	assign clearing = (state_q == ST_CLEAR);
	assign do_upd = (state_q == ST_EXEC) && op_q.is_update;
	assign clr_hist = {1'b0, clr_q} < (CLR_W + 1)'(LOCAL_ENTRIES);
	assign clr_ctr = {1'b0, clr_q} < (CLR_W + 1)'(PAT_N);
	assign out_ok = !out_valid_q || out_ready;

	// saturating counter step
	always_comb begin
		if (op_q.taken) begin
			ctr_next = (ctr_rdata == CTR_MAX) ? ctr_rdata : ctr_rdata + CTR_BITS'(1);
		end else begin
			ctr_next = (ctr_rdata == '0) ? ctr_rdata : ctr_rdata - CTR_BITS'(1);
		end
	end

	always_comb begin
		hist_raddr = (state_q == ST_IDLE) ? head_slot : slot_q;
		ctr_raddr = (state_q == ST_CTR) ? hist_rdata : hist_q;

		hist_we = clearing ? clr_hist : do_upd;
		hist_waddr = clearing ? clr_q[SLOT_W-1:0] : slot_q;
		hist_wdata = clearing ? '0 : HIST_BITS'({hist_q, op_q.taken});

		ctr_we = clearing ? clr_ctr : do_upd;
		ctr_waddr = clearing ? clr_q[HIST_BITS-1:0] : hist_q;
		ctr_wdata = clearing ? '0 : ctr_next;
	end

	always_comb begin
		stat.pop = (state_q == ST_IDLE) && head.valid;
		stat.init_done = !clearing;
	end

	lhbp_ram #(
		.WIDTH (HIST_BITS),
		.DEPTH (LOCAL_ENTRIES)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	lhbp_ram #(
		.WIDTH (CTR_BITS),
		.DEPTH (PAT_N)
	) u_ctr_ram (
		.clk   (clk),
		.we    (ctr_we),
		.waddr (ctr_waddr),
		.wdata (ctr_wdata),
		.raddr (ctr_raddr),
		.rdata (ctr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			pred_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						state_q <= ST_CTR;
					end
				end
				ST_CTR: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (op_q.is_update) begin
						state_q <= ST_IDLE;
					end else if (out_ok) begin
						out_valid_q <= 1'b1;
						pred_q <= ctr_rdata[CTR_BITS-1];
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (stat.pop) begin
			slot_q <= head_slot;
			op_q <= head.op;
		end
		if (state_q == ST_CTR) begin
			hist_q <= hist_rdata;
		end
	end

	assign out_valid = out_valid_q;
	assign predict_taken = pred_q;

endmodule

// ===== design/local_history_branch_predictor.sv =====
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+----------------------------------
// cfg       | in        | cfg_valid / cfg_ready | cfg_data (inst_shift)
// in        | in        | in_valid / in_ready   | req_type, pc, taken
// out       | out       | out_valid / out_ready | predict_taken
//
// in the back end each request goes through a history read, a counter read,
// then counter and history write-back or result load; a lookup waits in the
// last step while the output register is still full
// after reset both tables are cleared by a counter running over
// max(LOCAL_ENTRIES, 2**HIST_BITS) addresses (1024 by default); in_ready stays low meanwhile, cfg is always taken
// a two-entry queue keeps taking requests until full while the back end works or waits
// on out_ready; updates produce no out transaction
module local_history_branch_predictor #(
	parameter int unsigned LOCAL_ENTRIES = 1024,
	parameter int unsigned HIST_BITS     = 10,
	parameter int unsigned CTR_BITS      = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lhbp_pkg::SHIFT_W-1:0]        cfg_data,
	// requests
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [lhbp_pkg::ADDR_W-1:0]         pc,
	input  logic                                taken,
	// predictions
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                predict_taken
);

	import lhbp_pkg::*;

	localparam int unsigned SLOT_W = $clog2(LOCAL_ENTRIES);

	logic [SHIFT_W-1:0] inst_shift_q;
	lhbp_head_t         head;
	lhbp_stat_t         stat;
	logic [SLOT_W-1:0]  head_slot;

	// the user must change the register only while the block is idle; the block itself does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inst_shift_q <= INST_SHIFT_RST;
		end else if (cfg_valid && cfg_ready) begin
			inst_shift_q <= cfg_data;
		end
	end

	// front end: forms the history slot and queues the request
	lhbp_front #(
		.LOCAL_ENTRIES (LOCAL_ENTRIES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.pc          (pc),
		.taken       (taken),
		.inst_shift  (inst_shift_q),
		.stat        (stat),
		.head        (head),
		.head_slot   (head_slot)
	);

	// back end: table clear, lookups and updates, output register
	lhbp_back #(
		.LOCAL_ENTRIES (LOCAL_ENTRIES),
		.HIST_BITS     (HIST_BITS),
		.CTR_BITS      (CTR_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_slot     (head_slot),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.predict_taken (predict_taken)
	);

endmodule

// ===== design/lhbp_checker.sv =====
module lhbp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          predict_taken
);

	// a stalled prediction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before its transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(predict_taken))
		else $error("predict_taken changed while stalled");

	// configuration writes are never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg write was stalled");

	// table clear runs right after reset release
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready)
		else $error("request taken before table clear");

endmodule

bind local_history_branch_predictor lhbp_checker u_lhbp_checker (.*);

// ===== sim/tb_local_history_branch_predictor.sv =====
module tb_local_history_branch_predictor;
	timeunit 1ns;
	timeprecision 1ps;

	import lhbp_pkg::*;

	// block configuration under test
	localparam int unsigned LOCAL_ENTRIES = 1024;
	localparam int unsigned HIST_BITS     = 10;
	localparam int unsigned CTR_BITS      = 2;
	localparam int unsigned SLOT_W        = $clog2(LOCAL_ENTRIES);
	localparam int unsigned PAT_ENTRIES   = 1 << HIST_BITS;

	// run shape
	localparam int unsigned N_PHASES        = 8;
	localparam int unsigned ITEMS_PER_PHASE = 150;
	localparam int unsigned N_HOT           = 10;
	localparam int unsigned HOLD_PHASE      = 2;
	localparam int unsigned HOLD_LEN        = 300;
	// back end reads history, then the counter, then writes back, behind a 2-entry
	// queue, so an update may still be writing back after the last prediction has left
	localparam int unsigned SETTLE          = 12;
	// covers the table clearing pass after reset plus the long receiver hold
	localparam int unsigned STALL_LIMIT     = 5000;

	localparam logic [SHIFT_W-1:0] PHASE_SHIFT [6] = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0};

	// behavior of a frequently seen branch in the random part
	typedef enum int unsigned {
		BR_ALWAYS,
		BR_NEVER,
		BR_LOOP,
		BR_ALTERNATE,
		BR_NOISY
	} branch_kind_t;

	// mirror of the PAg tables plus the queue of predictions still owed
	class pag_board_t;
		bit [HIST_BITS-1:0] hist_tab [LOCAL_ENTRIES];
		bit [CTR_BITS-1:0]  ctr_tab [PAT_ENTRIES];
		bit [SHIFT_W-1:0]   shift;
		logic               predictions_due[$];
		int unsigned        errors;
		int unsigned        checked;
		int unsigned        lookups;
		int unsigned        updates;
		int unsigned        taken_preds;

		function new();
			shift = INST_SHIFT_RST;
			errors = 0;
			checked = 0;
			lookups = 0;
			updates = 0;
			taken_preds = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("[%0t] mismatch: %s", $realtime, msg);
			end
		endfunction

		function void set_shift(logic [SHIFT_W-1:0] v);
			shift = v;
		endfunction

		function int unsigned pending();
			return predictions_due.size();
		endfunction

		function void note_req(lhbp_req_t rt, logic [ADDR_W-1:0] addr, logic tk);
			logic [ADDR_W-1:0]  shifted;
			bit [SLOT_W-1:0]    slot;
			bit [HIST_BITS-1:0] hist;
			bit [CTR_BITS-1:0]  ctr;
			shifted = addr >> shift;
			slot = SLOT_W'(shifted & ADDR_W'(LOCAL_ENTRIES - 1));
			hist = hist_tab[slot];
			ctr = ctr_tab[hist];
			if (rt == REQ_LOOKUP) begin
				lookups++;
				predictions_due.push_back(ctr[CTR_BITS-1]);
			end else begin
				updates++;
				if (tk) begin
					if (ctr != {CTR_BITS{1'b1}})
						ctr++;
				end else begin
					if (ctr != '0)
						ctr--;
				end
				ctr_tab[hist] = ctr;
				hist_tab[slot] = {hist[HIST_BITS-2:0], tk};
			end
		endfunction

		function void check_pred(logic got);
			logic want;
			if (predictions_due.size() == 0) begin
				flag($sformatf("prediction %0b with nothing pending", got));
				return;
			end
			want = predictions_due.pop_front();
			checked++;
			if (got === 1'b1)
				taken_preds++;
			if (got !== want)
				flag($sformatf("predict_taken expected %0b got %0b", want, got));
		endfunction

		function void finish_check();
			if (predictions_due.size() != 0)
				flag($sformatf("%0d predictions never arrived", predictions_due.size()));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [SHIFT_W-1:0] cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic [ADDR_W-1:0]  pc;
	logic               taken;
	logic               out_valid;
	logic               out_ready;
	logic               predict_taken;

	pag_board_t sb = new();

	// no random idling on either side once set
	bit calm = 1'b0;
	// asks the receiver for its one long hold
	bit hold_now = 1'b0;
	int unsigned shifts_used = 0;

	logic [ADDR_W-1:0] hot_addr [N_HOT];
	branch_kind_t      hot_kind [N_HOT];
	int unsigned       hot_period [N_HOT];
	int unsigned       hot_iter [N_HOT];

	local_history_branch_predictor #(
		.LOCAL_ENTRIES(LOCAL_ENTRIES),
		.HIST_BITS(HIST_BITS),
		.CTR_BITS(CTR_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.pc(pc),
		.taken(taken),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.predict_taken(predict_taken)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// one request transaction; the predictor sees it at the accepting edge
	task automatic send_req(input lhbp_req_t rt, input logic [ADDR_W-1:0] a, input logic tk);
		// occasional sender gap, valid drops only when a gap follows
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		pc <= a;
		taken <= tk;
		do @(posedge clk); while (!in_ready);
		sb.note_req(rt, a, tk);
	endtask

	// config transaction; only called with the block idle
	task automatic write_shift(input logic [SHIFT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_shift(v);
		shifts_used++;
	endtask

	// wait for every owed prediction, then let trailing updates write back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// outcome of a hot branch following its behavior
	function automatic logic next_outcome(int unsigned i);
		logic tk;
		case (hot_kind[i])
			BR_ALWAYS:    tk = 1'b1;
			BR_NEVER:     tk = 1'b0;
			BR_LOOP:      tk = (hot_iter[i] % hot_period[i]) != hot_period[i] - 1;
			BR_ALTERNATE: tk = hot_iter[i][0];
			default:      tk = 1'($urandom_range(0, 1));
		endcase
		hot_iter[i]++;
		return tk;
	endfunction

	// fresh set of hot branches; the last four alias an earlier one's history slot
	task automatic build_hot_set();
		logic [ADDR_W-1:0] upper;
		for (int i = 0; i < N_HOT; i++) begin
			if (i < 6) begin
				hot_addr[i] = {$urandom, $urandom};
			end else begin
				upper = {$urandom, $urandom};
				hot_addr[i] = hot_addr[i-6] ^ ((upper | 1) << (sb.shift + SLOT_W));
			end
			hot_kind[i] = branch_kind_t'($urandom_range(0, 4));
			hot_period[i] = $urandom_range(2, 12);
			hot_iter[i] = 0;
		end
	endtask

	// result side: prediction transactions checked against the mirror
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pred(predict_taken);
	end

	// receiver: random stall bursts, one long hold so the queue backs up
	initial begin : rx_side
		int unsigned stall_left;
		bit          held_long;
		stall_left = 0;
		held_long = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_now && !held_long) begin
				held_long = 1'b1;
				stall_left = HOLD_LEN;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 16);
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog: ends the run when no transaction moves for too long
	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no transaction for %0d cycles, %0d predictions pending",
			STALL_LIMIT, sb.pending());
		$display("tb_local_history_branch_predictor: errors");
		$finish;
	end

	initial begin : stimulus
		int unsigned        n;
		int unsigned        i;
		logic [SHIFT_W-1:0] next_shift;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		req_type <= REQ_LOOKUP;
		pc <= '0;
		taken <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset shift of 2, slot = addr[11:2]
		// cold tables predict not taken at both address extremes
		send_req(REQ_LOOKUP, 64'h0, 1'b0);
		send_req(REQ_LOOKUP, '1, 1'b1);
		// not-taken on a zero counter stays at the floor
		send_req(REQ_UPDATE, 64'h0, 1'b0);
		// separate slots with zero history all train the shared counter 0
		send_req(REQ_UPDATE, 64'h4, 1'b1);
		send_req(REQ_UPDATE, 64'h8, 1'b1);
		send_req(REQ_LOOKUP, 64'h0, 1'b0);
		send_req(REQ_UPDATE, 64'hc, 1'b1);
		// counter already at max, saturates high
		send_req(REQ_UPDATE, 64'h10, 1'b1);
		send_req(REQ_LOOKUP, 64'h0, 1'b0);
		// walk counter 0 back down through the threshold and past the floor
		send_req(REQ_UPDATE, 64'h0, 1'b0);
		send_req(REQ_UPDATE, 64'h0, 1'b0);
		send_req(REQ_LOOKUP, 64'h0, 1'b0);
		send_req(REQ_UPDATE, 64'h0, 1'b0);
		send_req(REQ_UPDATE, 64'h0, 1'b0);
		// taken is ignored on a lookup
		send_req(REQ_LOOKUP, 64'h4, 1'b1);
		// address bits above the slot index do not matter
		send_req(REQ_UPDATE, 64'hffff_ffff_ffff_f004, 1'b1);
		send_req(REQ_LOOKUP, 64'h8000_0000_0000_0000, 1'b1);
		// bits below the shift do not matter either
		send_req(REQ_LOOKUP, 64'h3, 1'b0);
		send_req(REQ_LOOKUP, 64'h5, 1'b0);

		// random phases, each under its own shift setting
		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			if (p == N_PHASES - 1)
				calm = 1'b1;
			next_shift = (p < 6) ? PHASE_SHIFT[p] : SHIFT_W'($urandom_range(0, 3));
			write_shift(next_shift);
			build_hot_set();
			if (p == HOLD_PHASE)
				hold_now = 1'b1;
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 4) != 0) begin
					// well-formed use: usually a lookup, then the resolved update
					i = $urandom_range(0, N_HOT - 1);
					if ($urandom_range(0, 3) != 0) begin
						send_req(REQ_LOOKUP, hot_addr[i], 1'($urandom_range(0, 1)));
						n++;
					end
					send_req(REQ_UPDATE, hot_addr[i], next_outcome(i));
					n++;
				end else begin
					// noise on random addresses
					send_req(lhbp_req_t'($urandom_range(0, 1)), {$urandom, $urandom},
						1'($urandom_range(0, 1)));
					n++;
				end
			end
		end
		drain();

		sb.finish_check();
		$display("covered %0d lookups and %0d updates across %0d shift writes",
			sb.lookups, sb.updates, shifts_used);
		$display("%0d predictions checked, %0d of them taken, %0d errors",
			sb.checked, sb.taken_preds, sb.errors);
		if (sb.errors == 0) begin
			$display("tb_local_history_branch_predictor: clean");
		end else begin
			$display("tb_local_history_branch_predictor: errors");
		end
		$finish;
	end

endmodule
